// ----- rtl/psls_pkg.sv -----
// ----------------------------------------------------------------------------
// psls_pkg
// Shared types and command/status structs for the pairwise segment sorter.
// ----------------------------------------------------------------------------
package psls_pkg;

    typedef struct packed {
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic               final_point;
    } point_word_t;

    typedef struct packed {
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] first_z;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] second_z;
        logic        [33:0] squared_length;
        logic               last_segment;
    } segment_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAIR,
        ST_SEARCH,
        ST_EMIT,
        ST_DONE
    } psls_state_t;

    typedef struct packed {
        logic load;        // store incoming point
        logic clr_count;   // empty the set
        logic pair_init;   // start pair walk
        logic pair_step;   // compute one pair length, advance
        logic srch_init;   // start min search over pairs
        logic srch_step;   // compare one pair
        logic emit;        // output chosen pair, mark used
    } psls_cmd_t;

    typedef struct packed {
        logic enough;      // at least two points
        logic pair_done;   // all pairs formed
        logic srch_done;   // search pass complete
        logic all_out;     // every pair emitted
    } psls_stat_t;

endpackage

// ----- rtl/psls_datapath.sv -----
// ----------------------------------------------------------------------------
// psls_datapath
// Point store, pair length unit, pair table and min-search selector.
// ----------------------------------------------------------------------------
module psls_datapath
    import psls_pkg::*;
#(
    parameter int MAX_POINTS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  point_word_t   in_word,
    input  psls_cmd_t     cmd,
    output psls_stat_t    stat,
    output segment_word_t out_word
);
    localparam int PairCap = MAX_POINTS * (MAX_POINTS - 1) / 2;
    localparam int IW = $clog2(MAX_POINTS + 1);
    localparam int PIW = $clog2(MAX_POINTS);
    localparam int KW = $clog2(PairCap + 1);
    localparam int KIW = (PairCap > 1) ? $clog2(PairCap) : 1;

    logic [47:0]    store_mem [MAX_POINTS];
    logic [IW-1:0]  count_reg;
    logic [IW-1:0]  pi_reg, pj_reg;
    logic [KW-1:0]  npair_reg;
    logic [PIW-1:0] pa_mem [PairCap];
    logic [PIW-1:0] pb_mem [PairCap];
    logic [33:0]    len_mem [PairCap];
    logic [PairCap-1:0] used_reg;
    logic [KW-1:0]  scan_reg;
    logic [KW-1:0]  best_reg;
    logic           best_ok_reg;
    logic [KW-1:0]  emitted_reg;

    logic [47:0] p_rd, q_rd;
    logic [16:0] dx, dy, dz;
    logic [16:0] ax, ay, az;
    logic [31:0] sqx, sqy, sqz;
    logic [33:0] len_sum;
    logic [KIW-1:0] scan_idx, best_idx;

    assign p_rd = store_mem[pi_reg[PIW-1:0]];
    assign q_rd = store_mem[pj_reg[PIW-1:0]];
    assign dx = {p_rd[47], p_rd[47:32]} - {q_rd[47], q_rd[47:32]};
    assign dy = {p_rd[31], p_rd[31:16]} - {q_rd[31], q_rd[31:16]};
    assign dz = {p_rd[15], p_rd[15:0]} - {q_rd[15], q_rd[15:0]};
    assign ax = dx[16] ? -dx : dx;
    assign ay = dy[16] ? -dy : dy;
    assign az = dz[16] ? -dz : dz;
    assign sqx = ax[15:0] * ax[15:0];
    assign sqy = ay[15:0] * ay[15:0];
    assign sqz = az[15:0] * az[15:0];
    assign len_sum = 34'(sqx) + 34'(sqy) + 34'(sqz);
    assign scan_idx = scan_reg[KIW-1:0];
    assign best_idx = best_reg[KIW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load && count_reg < IW'(MAX_POINTS))
        begin
            store_mem[count_reg[PIW-1:0]] <= {in_word.coord_x, in_word.coord_y,
                                              in_word.coord_z};
        end
        if (cmd.pair_step)
        begin
            pa_mem[npair_reg[KIW-1:0]]  <= pi_reg[PIW-1:0];
            pb_mem[npair_reg[KIW-1:0]]  <= pj_reg[PIW-1:0];
            len_mem[npair_reg[KIW-1:0]] <= len_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pi_reg      <= '0;
            pj_reg      <= '0;
            npair_reg   <= '0;
            used_reg    <= '0;
            scan_reg    <= '0;
            best_reg    <= '0;
            best_ok_reg <= 1'b0;
            emitted_reg <= '0;
        end
        else
        begin
            if (cmd.clr_count)
                count_reg <= '0;
            else if (cmd.load && count_reg < IW'(MAX_POINTS))
                count_reg <= count_reg + 1'b1;
            if (cmd.pair_init)
            begin
                pi_reg      <= '0;
                pj_reg      <= IW'(1);
                npair_reg   <= '0;
                used_reg    <= '0;
                emitted_reg <= '0;
            end
            else if (cmd.pair_step)
            begin
                npair_reg <= npair_reg + 1'b1;
                if (pj_reg + 1'b1 == count_reg)
                begin
                    pi_reg <= pi_reg + 1'b1;
                    pj_reg <= pi_reg + IW'(2);
                end
                else
                    pj_reg <= pj_reg + 1'b1;
            end
            if (cmd.srch_init)
            begin
                scan_reg    <= '0;
                best_ok_reg <= 1'b0;
            end
            else if (cmd.srch_step)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (!used_reg[scan_idx] &&
                    (!best_ok_reg || len_mem[scan_idx] < len_mem[best_idx]))
                begin
                    best_reg    <= scan_reg;
                    best_ok_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                used_reg[best_idx] <= 1'b1;
                emitted_reg        <= emitted_reg + 1'b1;
            end
        end
    end

    logic [47:0] a_rd, b_rd;
    assign a_rd = store_mem[pa_mem[best_idx]];
    assign b_rd = store_mem[pb_mem[best_idx]];

    always_comb
    begin
        out_word.first_x        = a_rd[47:32];
        out_word.first_y        = a_rd[31:16];
        out_word.first_z        = a_rd[15:0];
        out_word.second_x       = b_rd[47:32];
        out_word.second_y       = b_rd[31:16];
        out_word.second_z       = b_rd[15:0];
        out_word.squared_length = len_mem[best_idx];
        out_word.last_segment   = (emitted_reg + 1'b1 == npair_reg);
    end

    assign stat.enough    = (count_reg >= IW'(2));
    assign stat.pair_done = (pi_reg + 1'b1 >= count_reg);
    assign stat.srch_done = (scan_reg == npair_reg);
    assign stat.all_out   = (emitted_reg == npair_reg);

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IW'(MAX_POINTS))
        else $error("point count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        npair_reg <= KW'(PairCap))
        else $error("pair count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> best_ok_reg && !used_reg[best_idx])
        else $error("emitting an unselected or used pair");
endmodule

// ----- rtl/psls_ctrl.sv -----
// ----------------------------------------------------------------------------
// psls_ctrl
// Sequencer: load points, form pairs, then repeated min-search and emit.
// ----------------------------------------------------------------------------
module psls_ctrl
    import psls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        final_point,
    input  psls_stat_t  stat,
    output psls_cmd_t   cmd,
    output logic        busy,
    output logic        strobe
);
    psls_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        strobe     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (final_point)
                        state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.pair_init = 1'b1;
                if (stat.enough)
                    state_next = ST_PAIR;
                else
                begin
                    cmd.clr_count = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_PAIR:
            begin
                cmd.pair_step = 1'b1;
                if (stat.pair_done)
                begin
                    cmd.pair_step = 1'b0;
                    cmd.srch_init = 1'b1;
                    state_next    = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (stat.srch_done)
                    state_next = ST_EMIT;
                else
                    cmd.srch_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.srch_init = 1'b1;
                strobe        = 1'b1;
                state_next    = ST_SEARCH;
                if (stat.all_out)
                begin
                    cmd.emit      = 1'b0;
                    cmd.srch_init = 1'b0;
                    strobe        = 1'b0;
                    cmd.clr_count = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> state_reg == ST_EMIT)
        else $error("strobe outside emit");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy)
        else $error("load while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> busy)
        else $error("idle right after a result");
endmodule

// ----- rtl/pairwise_segment_length_sort_top.sv -----
// ----------------------------------------------------------------------------
// pairwise_segment_length_sort_top
// Sorts all point pairs of a set by squared length.
// ----------------------------------------------------------------------------
// Points load while busy is low and start is high. The point marked final
// starts the sort: with n points and P = n(n-1)/2 pairs, a setup step is
// followed by pair forming, then each result costs a full scan of the pair
// table plus an emit step, and one more scan closes the set. Results appear
// one per strobe and cannot be held off; busy stays high until the closing
// scan is done.
// ----------------------------------------------------------------------------
module pairwise_segment_length_sort_top
    import psls_pkg::*;
#(
    parameter int MAX_POINTS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  point_word_t   point,
    output logic          strobe,
    output segment_word_t segment
);
    psls_cmd_t  cmd;
    psls_stat_t stat;

    psls_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .final_point (point.final_point),
        .stat        (stat),
        .cmd         (cmd),
        .busy        (busy),
        .strobe      (strobe)
    );

    psls_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (point),
        .cmd      (cmd),
        .stat     (stat),
        .out_word (segment)
    );
endmodule
